// ===== sv/mavg_pkg.sv =====
// Shared package for the moving average filter.
// Holds widths, default sizes, controller state codes and control/status structs.
// No dependencies.
package mavg_pkg;

	localparam int SAMPLE_W       = 16;
	localparam int WIN_W          = 7;
	localparam int MAX_WINDOW_DEF = 64;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_LOAD,
		ST_DIV,
		ST_DONE
	} mavg_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic update;
		logic div_load;
		logic div_step;
		logic out_load;
	} mavg_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic n_zero;
		logic div_last;
		logic out_free;
	} mavg_status_t;

endpackage

// ===== sv/mavg_ctrl.sv =====
// Controller state machine of the moving average filter.
// Sequences ring update, divider load, divider steps and result handoff.
// Depends on mavg_pkg.
module mavg_ctrl
	import mavg_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  mavg_status_t status,
	output mavg_cmd_t    cmd
);

	mavg_state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				// With a zero window the request is taken and dropped.
				if (in_valid && !status.n_zero) state_next = ST_UPDATE;
			end
			ST_UPDATE: state_next = ST_LOAD;
			ST_LOAD:   state_next = ST_DIV;
			ST_DIV: begin
				if (status.div_last) state_next = ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free) state_next = ST_IDLE;
			end
			default:   state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		cmd          = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid && !status.n_zero;
			end
			ST_UPDATE: cmd.update   = 1'b1;
			ST_LOAD:   cmd.div_load = 1'b1;
			ST_DIV:    cmd.div_step = 1'b1;
			ST_DONE:   cmd.out_load = status.out_free;
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// ===== sv/mavg_datapath.sv =====
// Datapath of the moving average filter: sample ring memory, running sum,
// serial restoring divider and output register.
// Depends on mavg_pkg.
module mavg_datapath
	import mavg_pkg::*;
#(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [WIN_W-1:0]           cfg_wdata,
	input  logic signed [SAMPLE_W-1:0] in_sample,
	input  mavg_cmd_t                  cmd,
	output mavg_status_t               status,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] out_average
);

	localparam int PW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int FW   = $clog2(MAX_WINDOW + 1);
	localparam int SW   = SAMPLE_W + $clog2(MAX_WINDOW);
	localparam int CNTW = $clog2(SW + 1);

	logic [WIN_W-1:0]           win_q;
	logic [WIN_W-1:0]           n_eff;
	logic [PW-1:0]              pos_q;
	logic [FW-1:0]              fill_q;
	logic signed [SW-1:0]       sum_q;
	logic signed [SAMPLE_W-1:0] ring_mem [MAX_WINDOW];
	logic signed [SAMPLE_W-1:0] rd_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic signed [SAMPLE_W-1:0] old_sample;
	logic [PW:0]                pos_inc;
	logic                       slot_valid;
	logic [SW-1:0]              quot_q;
	logic [WIN_W-1:0]           rem_q;
	logic                       neg_q;
	logic [CNTW-1:0]            cnt_q;
	logic [WIN_W:0]             trial;
	logic                       trial_ge;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_data_q;

	// A window above the ring size saturates to the ring size.
	assign n_eff = (32'(win_q) > MAX_WINDOW) ? WIN_W'(MAX_WINDOW) : win_q;

	// Slots at or above the fill count have not been written since the last
	// clear and read as zero, so the ring needs no clearing pass.
	assign slot_valid = 32'(pos_q) < 32'(fill_q);
	assign old_sample = slot_valid ? rd_q : '0;
	assign pos_inc    = {1'b0, pos_q} + 1'b1;

	assign trial    = {rem_q, quot_q[SW-1]};
	assign trial_ge = trial >= {1'b0, n_eff};

	assign status.n_zero   = (n_eff == '0);
	assign status.div_last = (cnt_q == CNTW'(1));
	assign status.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rd_q <= ring_mem[pos_q];
		end
		if (cmd.update) begin
			ring_mem[pos_q] <= sample_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= '0;
			pos_q  <= '0;
			fill_q <= '0;
			sum_q  <= '0;
		end else if (cfg_we) begin
			win_q  <= cfg_wdata;
			pos_q  <= '0;
			fill_q <= '0;
			sum_q  <= '0;
		end else if (cmd.update) begin
			sum_q <= sum_q - SW'(old_sample) + SW'(sample_q);
			if (FW'(pos_q) == fill_q) begin
				fill_q <= fill_q + 1'b1;
			end
			if (32'(pos_inc) >= 32'(n_eff)) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_inc[PW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sample_q <= in_sample;
		end
		if (cmd.div_load) begin
			neg_q  <= sum_q[SW-1];
			quot_q <= sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
			rem_q  <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= trial_ge ? WIN_W'(trial - {1'b0, n_eff}) : trial[WIN_W-1:0];
			quot_q <= {quot_q[SW-2:0], trial_ge};
		end
		if (cmd.out_load) begin
			out_data_q <= neg_q ? -quot_q[SAMPLE_W-1:0] : quot_q[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.div_load) begin
				cnt_q <= CNTW'(SW);
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_average = out_data_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= MAX_WINDOW)
		else $error("fill count exceeds ring size");

	a_pos_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> 32'(pos_q) < 32'(n_eff))
		else $error("write position outside window at update");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result register loaded while holding an untaken request");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_load |=> cnt_q == CNTW'(SW))
		else $error("divider count not loaded");

endmodule

// ===== sv/moving_average_filter_unit.sv =====
// Moving average filter top level, built from mavg_ctrl and mavg_datapath (uses mavg_pkg).
// An accepted sample passes the ring update, divider load and divider steps for an SW-bit
// quotient (SW = 16 + log2(MAX_WINDOW), 22 at the default size; one bit per cycle from the
// restoring divider that divides by N), then the done state loads the output register. A new
// request is taken once the result is loaded; loading waits while an earlier result is untaken.
// Asynchronous active-low reset clears window register, write position, fill count and sum.
module moving_average_filter_unit
	import mavg_pkg::*;
#(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [WIN_W-1:0]           cfg_wdata,      // window_length
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic signed [SAMPLE_W-1:0] s_axis_tdata,   // [15:0] sample
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic signed [SAMPLE_W-1:0] m_axis_tdata    // [15:0] average
);

	mavg_cmd_t    cmd;
	mavg_status_t status;

	mavg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	mavg_datapath #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_sample   (s_axis_tdata),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_average (m_axis_tdata)
	);

endmodule
